@@ src/hrp_pkg.sv @@
// hrp_pkg: types, codes, match tables and byte-step helper functions
// for the HTTP request header parser. No dependencies.
package hrp_pkg;

	localparam int MAX_BUFFER_BYTES = 4096;
	localparam int MAX_HEADER_SLOTS = 64;
	localparam int HDR_LIMIT        = MAX_HEADER_SLOTS / 2;

	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_NUL   = 8'h00;

	localparam logic [1:0] PH_LINE = 2'd0;
	localparam logic [1:0] PH_HEAD = 2'd1;
	localparam logic [1:0] PH_DONE = 2'd2;

	localparam logic [1:0] FLD_METHOD  = 2'd0;
	localparam logic [1:0] FLD_PATH    = 2'd1;
	localparam logic [1:0] FLD_VERSION = 2'd2;

	localparam logic [1:0] HM_NONE  = 2'd0;
	localparam logic [1:0] HM_NAME  = 2'd1;
	localparam logic [1:0] HM_VALUE = 2'd2;

	localparam logic [1:0] KIND_LINE   = 2'd0;
	localparam logic [1:0] KIND_HEADER = 2'd1;
	localparam logic [1:0] KIND_FINAL  = 2'd2;

	localparam logic [2:0] ST_OK          = 3'd0;
	localparam logic [2:0] ST_NO_CRLF     = 3'd1;
	localparam logic [2:0] ST_BAD_METHOD  = 3'd2;
	localparam logic [2:0] ST_EMPTY_PATH  = 3'd3;
	localparam logic [2:0] ST_BAD_VERSION = 3'd4;
	localparam logic [2:0] ST_TOO_MANY    = 3'd5;

	localparam logic [2:0] METH_DELETE = 3'd4;
	localparam logic [1:0] VER_11      = 2'd2;

	localparam logic [3:0] METH_LEN [5] = '{4'd3, 4'd4, 4'd4, 4'd3, 4'd6};
	localparam logic [7:0] METH_CHARS [5][8] = '{
		'{"G", "E", "T", 8'h0, 8'h0, 8'h0, 8'h0, 8'h0},
		'{"H", "E", "A", "D", 8'h0, 8'h0, 8'h0, 8'h0},
		'{"P", "O", "S", "T", 8'h0, 8'h0, 8'h0, 8'h0},
		'{"P", "U", "T", 8'h0, 8'h0, 8'h0, 8'h0, 8'h0},
		'{"D", "E", "L", "E", "T", "E", 8'h0, 8'h0}
	};
	localparam logic [7:0] VER_CHARS [3][8] = '{
		'{"H", "T", "T", "P", "/", "0", ".", "9"},
		'{"H", "T", "T", "P", "/", "1", ".", "0"},
		'{"H", "T", "T", "P", "/", "1", ".", "1"}
	};

	typedef struct packed {
		logic [1:0]  field;
		logic [4:0]  mcand;
		logic [3:0]  fci;
		logic [2:0]  vcand;
		logic [11:0] path_begin;
		logic [12:0] path_size;
		logic        cut;
	} line_t;

	typedef struct packed {
		logic [1:0]  phase;
		logic [11:0] pos;
		line_t       line;
		logic        prev_cr;
		logic [1:0]  hmode;
		logic        skip;
		logic [11:0] name_begin;
		logic [12:0] name_size;
		logic [11:0] value_begin;
		logic [5:0]  hseen;
		logic [2:0]  err;
	} state_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [2:0]  method;
		logic [1:0]  version;
		logic [11:0] first_start;
		logic [12:0] first_length;
		logic [11:0] second_start;
		logic [12:0] second_length;
		logic [2:0]  status;
		logic        last;
	} word_t;

	// up to two words per byte, compacted so that word 0 is filled first
	typedef struct packed {
		logic [1:0] count;
		word_t      w0;
		word_t      w1;
	} push_t;

	function automatic state_t init_state();
		state_t s;
		s = '0;
		s.phase      = PH_LINE;
		s.line.field = FLD_METHOD;
		s.line.mcand = 5'b11111;
		s.line.vcand = 3'b111;
		s.hmode      = HM_NONE;
		s.err        = ST_OK;
		return s;
	endfunction

	function automatic logic [4:0] close_method(logic [4:0] mc, logic [3:0] k);
		logic [4:0] r;
		r = mc;
		for (int m = 0; m < 5; m++)
			if (METH_LEN[m] != k) r[m] = 1'b0;
		return r;
	endfunction

	function automatic line_t feed_line(line_t s, logic [7:0] c, logic [11:0] p);
		line_t      r;
		logic [3:0] k;
		r = s;
		k = s.fci;
		if (!s.cut) begin
			if (c == CH_NUL) begin
				r.cut = 1'b1;
			end else if (s.field == FLD_METHOD) begin
				if (c == CH_SP) begin
					r.mcand      = close_method(s.mcand, k);
					r.field      = FLD_PATH;
					r.path_begin = p + 12'd1;
					r.path_size  = '0;
				end else begin
					for (int m = 0; m < 5; m++)
						if (!(k < METH_LEN[m] && METH_CHARS[m][k[2:0]] == c))
							r.mcand[m] = 1'b0;
					if (k != 4'd15) r.fci = k + 4'd1;
				end
			end else if (s.field == FLD_PATH) begin
				if (c == CH_SP) begin
					r.field = FLD_VERSION;
					r.fci   = '0;
					r.vcand = 3'b111;
				end else begin
					r.path_size = s.path_size + 13'd1;
				end
			end else begin
				for (int m = 0; m < 3; m++)
					if (!(!k[3] && VER_CHARS[m][k[2:0]] == c))
						r.vcand[m] = 1'b0;
				if (k != 4'd15) r.fci = k + 4'd1;
			end
		end
		return r;
	endfunction

endpackage

@@ src/hrp_parser.sv @@
// hrp_parser: parser state register and the one-byte step logic.
// Depends on hrp_pkg.
module hrp_parser (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic [7:0]       data_byte,
	input  logic             end_of_buffer,
	output hrp_pkg::push_t   push
);

	hrp_pkg::state_t st_q;
	hrp_pkg::state_t nx;
	hrp_pkg::line_t  ln;
	hrp_pkg::word_t  res;
	hrp_pkg::word_t  fw;
	logic            res_v;
	logic            fin;
	logic [7:0]      hc;
	logic [11:0]     vb;
	logic [4:0]      mc;
	logic [2:0]      vc;
	logic [2:0]      lst;
	logic [2:0]      meth;
	logic [1:0]      ver;

	always_comb begin
		nx    = st_q;
		ln    = st_q.line;
		res   = '0;
		res_v = 1'b0;
		fw    = '0;
		hc    = '0;
		vb    = st_q.value_begin;
		mc    = '0;
		vc    = '0;
		lst   = hrp_pkg::ST_OK;
		meth  = '0;
		ver   = '0;
		fin   = end_of_buffer || (st_q.pos == 12'(hrp_pkg::MAX_BUFFER_BYTES - 1));

		case (st_q.phase)
			hrp_pkg::PH_LINE: begin
				if (st_q.prev_cr && data_byte == hrp_pkg::CH_LF) begin
					nx.prev_cr = 1'b0;
					mc = ln.mcand;
					vc = ln.vcand;
					if (ln.field == hrp_pkg::FLD_METHOD)
						mc = hrp_pkg::close_method(mc, ln.fci);
					if (ln.field == hrp_pkg::FLD_VERSION && ln.fci != 4'd8)
						vc = '0;
					if (mc[0]) meth = 3'd0;
					else if (mc[1]) meth = 3'd1;
					else if (mc[2]) meth = 3'd2;
					else if (mc[3]) meth = 3'd3;
					else meth = hrp_pkg::METH_DELETE;
					if (vc[0]) ver = 2'd0;
					else if (vc[1]) ver = 2'd1;
					else ver = hrp_pkg::VER_11;
					if (mc == '0)
						lst = hrp_pkg::ST_BAD_METHOD;
					else if (ln.field == hrp_pkg::FLD_METHOD || ln.path_size == '0)
						lst = hrp_pkg::ST_EMPTY_PATH;
					else if (ln.field == hrp_pkg::FLD_PATH || vc == '0)
						lst = hrp_pkg::ST_BAD_VERSION;
					else
						lst = hrp_pkg::ST_OK;
					res_v    = 1'b1;
					res.kind = hrp_pkg::KIND_LINE;
					if (lst == hrp_pkg::ST_OK) begin
						res.method       = meth;
						res.version      = ver;
						res.first_start  = ln.path_begin;
						res.first_length = ln.path_size;
						nx.phase         = hrp_pkg::PH_HEAD;
					end else begin
						res.status = lst;
						nx.err     = lst;
						nx.phase   = hrp_pkg::PH_DONE;
					end
				end else begin
					// a CR not followed by LF counts as line text
					if (st_q.prev_cr)
						ln = hrp_pkg::feed_line(ln, hrp_pkg::CH_CR, st_q.pos - 12'd1);
					nx.prev_cr = (data_byte == hrp_pkg::CH_CR);
					if (data_byte != hrp_pkg::CH_CR)
						ln = hrp_pkg::feed_line(ln, data_byte, st_q.pos);
					nx.line = ln;
					if (fin) nx.err = hrp_pkg::ST_NO_CRLF;
				end
			end
			hrp_pkg::PH_HEAD: begin
				hc = fin ? hrp_pkg::CH_NUL : data_byte;
				if (st_q.skip) begin
					if (hc == hrp_pkg::CH_SP) vb = st_q.pos + 12'd1;
					else nx.skip = 1'b0;
				end
				nx.value_begin = vb;
				if (st_q.hmode == hrp_pkg::HM_VALUE &&
				    (hc == hrp_pkg::CH_CR || hc == hrp_pkg::CH_LF)) begin
					if (st_q.hseen < 6'(hrp_pkg::HDR_LIMIT)) begin
						res_v             = 1'b1;
						res.kind          = hrp_pkg::KIND_HEADER;
						res.first_start   = st_q.name_begin;
						res.first_length  = st_q.name_size;
						res.second_start  = vb;
						res.second_length = {1'b0, st_q.pos} - {1'b0, vb};
						nx.hseen          = st_q.hseen + 6'd1;
						nx.hmode          = hrp_pkg::HM_NONE;
					end else begin
						nx.err   = hrp_pkg::ST_TOO_MANY;
						nx.phase = hrp_pkg::PH_DONE;
					end
				end else if (st_q.hmode == hrp_pkg::HM_NAME && hc == hrp_pkg::CH_COLON) begin
					nx.hmode       = hrp_pkg::HM_VALUE;
					nx.name_size   = {1'b0, st_q.pos} - {1'b0, st_q.name_begin};
					nx.value_begin = st_q.pos + 12'd1;
					nx.skip        = 1'b1;
				end else if (st_q.hmode == hrp_pkg::HM_NONE &&
				             ((hc >= "A" && hc <= "Z") || (hc >= "a" && hc <= "z"))) begin
					nx.hmode      = hrp_pkg::HM_NAME;
					nx.name_begin = st_q.pos;
				end
			end
			default: begin
			end
		endcase

		fw.kind   = hrp_pkg::KIND_FINAL;
		fw.status = nx.err;
		fw.last   = 1'b1;
		res.last  = !fin;

		if (fin) nx = hrp_pkg::init_state();
		else nx.pos = st_q.pos + 12'd1;

		push.count = {res_v & fin, res_v ^ fin};
		push.w0    = res_v ? res : fw;
		push.w1    = fw;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= hrp_pkg::init_state();
		else if (accept) st_q <= nx;
	end

endmodule

@@ src/hrp_out_fifo.sv @@
// hrp_out_fifo: four-entry result queue, takes up to two words a cycle
// and hands out one. Depends on hrp_pkg.
module hrp_out_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  hrp_pkg::push_t push,
	output logic           room2,
	output logic           rd_valid,
	input  logic           rd_take,
	output hrp_pkg::word_t rd_word
);

	hrp_pkg::word_t mem_q [4];
	logic [1:0]     wp_q;
	logic [1:0]     rp_q;
	logic [2:0]     cnt_q;
	logic [1:0]     n_in;
	logic           pop;

	assign n_in     = wr_en ? push.count : 2'd0;
	assign pop      = rd_valid && rd_take;
	assign rd_valid = (cnt_q != 3'd0);
	assign room2    = (cnt_q <= 3'd2);
	assign rd_word  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (n_in != 2'd0) mem_q[wp_q] <= push.w0;
		if (n_in == 2'd2) mem_q[wp_q + 2'd1] <= push.w1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + n_in;
			rp_q  <= rp_q + {1'b0, pop};
			cnt_q <= cnt_q + {1'b0, n_in} - {2'b0, pop};
		end
	end

endmodule

@@ src/http_request_header_parser.sv @@
// http_request_header_parser: top level, parser step plus result queue.
// Depends on hrp_pkg, hrp_parser, hrp_out_fifo.
//
// Input channel: one request byte per word (data_byte, end_of_buffer on the
// final byte). Output channel: one result word per handshake; kind says
// request line, header or final status, last marks the last word of a byte.
// Both channels: a word moves when valid is high and stall is low.
// A byte's results come from the parser state and land in a four-entry
// queue, so the first result is visible in the cycle after the byte is
// taken. One byte is taken per cycle while in_stall is low; the final byte
// of a buffer may yield two words, drained at one per cycle while out_stall
// is low. in_stall rises when the queue has fewer than two free entries, so
// while the receiver holds out_stall the queue fills to three or four words
// and then the input stalls. Reset empties the queue and puts the parser at
// the start of a buffer; after each final status it starts over.
module http_request_header_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        end_of_buffer,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [2:0]  method,
	output logic [1:0]  version,
	output logic [11:0] first_start,
	output logic [12:0] first_length,
	output logic [11:0] second_start,
	output logic [12:0] second_length,
	output logic [2:0]  status,
	output logic        last
);

	hrp_pkg::push_t push;
	hrp_pkg::word_t word;
	logic           room2;
	logic           accept;

	assign in_stall = !room2;
	assign accept   = in_valid && room2;

	hrp_parser u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.data_byte     (data_byte),
		.end_of_buffer (end_of_buffer),
		.push          (push)
	);

	hrp_out_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (accept),
		.push     (push),
		.room2    (room2),
		.rd_valid (out_valid),
		.rd_take  (!out_stall),
		.rd_word  (word)
	);

	assign kind          = word.kind;
	assign method        = word.method;
	assign version       = word.version;
	assign first_start   = word.first_start;
	assign first_length  = word.first_length;
	assign second_start  = word.second_start;
	assign second_length = word.second_length;
	assign status        = word.status;
	assign last          = word.last;

endmodule

@@ src/hrp_checker.sv @@
// hrp_checker: port-level checks for http_request_header_parser, bound
// to the top level. Depends on hrp_pkg.
module hrp_port_checks (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  kind,
	input logic [2:0]  method,
	input logic [11:0] first_start,
	input logic [12:0] first_length,
	input logic [2:0]  status,
	input logic        last
);

	// a stalled word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(kind) && $stable(status)
		&& $stable(last) && $stable(first_start))
		else $error("stalled output word changed");

	a_final_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == hrp_pkg::KIND_FINAL |-> last)
		else $error("final status word without last");

	// headers never come from the final byte, and carry no status
	a_header: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == hrp_pkg::KIND_HEADER |-> last && status == hrp_pkg::ST_OK)
		else $error("malformed header word");

	a_bad_line: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == hrp_pkg::KIND_LINE && status != hrp_pkg::ST_OK
		|-> method == '0 && first_length == '0)
		else $error("failed request line word carries fields");

endmodule

bind http_request_header_parser hrp_port_checks u_hrp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.kind         (kind),
	.method       (method),
	.first_start  (first_start),
	.first_length (first_length),
	.status       (status),
	.last         (last)
);
